// File: rtl/assert_macros.svh
// assertion macros shared by the route compute checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is active
`define RCU_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("route compute check failed");

// next-cycle implication, disabled while reset is active
`define RCU_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("route compute check failed");

`endif

// File: rtl/rcu_pkg.sv
// shared types and constants of the route compute unit
`timescale 1ns / 1ps

package rcu_pkg;

	localparam int NUM_VNETS_DEF = 4;
	localparam int DEST_BITS_DEF = 64;
	localparam int MAX_LINKS     = 16;
	localparam int LINK_W        = 4;
	localparam int ID_W          = 8;
	localparam int RND_W         = 16;
	localparam int DIVR_W        = 9;
	// torus radix is a power of two, coordinates are bit fields of the id
	localparam int TORUS_RADIX   = 4;
	localparam int TORUS_W       = 2;

	typedef enum logic [2:0] {
		CFG_ALGORITHM     = 3'd0,
		CFG_MY_ROUTER     = 3'd1,
		CFG_ROUTER_COUNT  = 3'd2,
		CFG_MESH_COLUMNS  = 3'd3,
		CFG_ORDERED_VNETS = 3'd4
	} cfg_idx_t;

	localparam logic [1:0] KIND_ROUTE  = 2'd0;
	localparam logic [1:0] KIND_SET    = 2'd1;
	localparam logic [1:0] KIND_WEIGHT = 2'd2;

	localparam logic [2:0] ALG_TABLE    = 3'd0;
	localparam logic [2:0] ALG_XY       = 3'd1;
	localparam logic [2:0] ALG_RING     = 3'd2;
	localparam logic [2:0] ALG_TORUS    = 3'd3;
	localparam logic [2:0] ALG_ADAPTIVE = 3'd4;
	localparam logic [2:0] ALG_BFLY     = 3'd5;
	localparam logic [2:0] ALG_RAILWAY  = 3'd6;
	localparam logic [2:0] ALG_SPARE    = 3'd7;

	localparam logic [4:0] DIR_TABLE = 5'd0;
	localparam logic [4:0] DIR_LOCAL = 5'd1;
	localparam logic [4:0] DIR_EAST  = 5'd2;
	localparam logic [4:0] DIR_WEST  = 5'd3;
	localparam logic [4:0] DIR_NORTH = 5'd4;
	localparam logic [4:0] DIR_SOUTH = 5'd5;
	localparam logic [4:0] DIR_CW    = 5'd6;
	localparam logic [4:0] DIR_CCW   = 5'd7;
	localparam logic [4:0] DIR_POSX  = 5'd8;
	localparam logic [4:0] DIR_NEGX  = 5'd9;
	localparam logic [4:0] DIR_POSY  = 5'd10;
	localparam logic [4:0] DIR_NEGY  = 5'd11;
	localparam logic [4:0] DIR_POSZ  = 5'd12;
	localparam logic [4:0] DIR_NEGZ  = 5'd13;
	localparam logic [4:0] DIR_UP    = 5'd14;
	localparam logic [4:0] DIR_DOWN  = 5'd15;
	localparam logic [4:0] DIR_LEFT  = 5'd16;
	localparam logic [4:0] DIR_RIGHT = 5'd17;

	typedef struct packed {
		logic              start;
		logic [RND_W-1:0]  dividend;
		logic [DIVR_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic              done;
		logic [RND_W-1:0]  quot;
		logic [DIVR_W-1:0] rem;
	} div_rsp_t;

endpackage

// File: rtl/rcu_ram.sv
// generic single-port-write ram with registered read
`timescale 1ns / 1ps

module rcu_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: rtl/rcu_div.sv
// restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps

module rcu_div import rcu_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	localparam int CNT_W = $clog2(RND_W + 1);

	logic              busy_q;
	logic              done_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [DIVR_W-1:0] rem_q;
	logic [RND_W-1:0]  quo_q;
	logic [DIVR_W-1:0] dvs_q;

	logic [DIVR_W:0]   trial;
	logic [DIVR_W:0]   diff;
	logic              ge;
	logic [DIVR_W-1:0] rem_nxt;

	always_comb begin
		trial   = {rem_q, quo_q[RND_W-1]};
		ge      = trial >= {1'b0, dvs_q};
		diff    = trial - {1'b0, dvs_q};
		rem_nxt = ge ? diff[DIVR_W-1:0] : trial[DIVR_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(RND_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= req.dividend;
			dvs_q <= req.divisor;
		end else if (busy_q) begin
			rem_q <= rem_nxt;
			quo_q <= {quo_q[RND_W-2:0], ge};
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = quo_q;
	assign rsp.rem  = rem_q;

endmodule

// File: rtl/noc_route_compute_unit.sv
// Route computation for one router: link table lookup or coordinate routing.
//
// Input channel (in_valid/in_stall) carries one item per transaction: a
// route request, a table set write or a link weight write. Writes produce
// nothing and keep the block idle. A route request gives one result transaction on
// the output channel (out_valid/out_stall).
// Torus, adaptive, butterfly and railway modes compute the direction from
// registered operands directly; xy mesh and ring first make two passes through
// the one-bit-per-cycle divider. Table use scans 16 links with one ram read each:
// with no match the result is ready after the scan, an ordered vnet walks to the
// first cheapest candidate, an unordered vnet first uses the divider to pick
// among the cheapest candidates, then walks to it. One request is in flight at a time;
// in_stall is high from acceptance until the result is in the output register.
// Reset clears the table (valid bits per entry), the link weights and the
// configuration. A stalled result holds in the output register while the
// block takes further writes; a new request finishes its work and waits
// in the done state until the old result is taken.
// Configuration writes (cfg_valid/cfg_ready) are always ready and are to be
// made only while the block is idle.
`timescale 1ns / 1ps

module noc_route_compute_unit import rcu_pkg::*; #(
	parameter int NUM_VNETS = NUM_VNETS_DEF,
	parameter int DEST_BITS = DEST_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [8:0]  cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  kind,
	input  logic [1:0]  vnet,
	input  logic [7:0]  dest_id,
	input  logic [63:0] dest_set,
	input  logic [3:0]  table_link,
	input  logic [63:0] entry_set,
	input  logic [7:0]  link_cost,
	input  logic [15:0] random_value,
	input  logic [7:0]  butterfly_queue,
	input  logic [7:0]  railway_queue,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [4:0]  direction,
	output logic [2:0]  stage,
	output logic [3:0]  out_link,
	output logic        no_route
);

	localparam int DEPTH  = NUM_VNETS * MAX_LINKS;
	localparam int ADDR_W = $clog2(DEPTH);

	typedef enum logic [6:0] {
		S_IDLE = 7'b0000001,
		S_SCAN = 7'b0000010,
		S_PREP = 7'b0000100,
		S_DIV  = 7'b0001000,
		S_SEL  = 7'b0010000,
		S_DIR  = 7'b0100000,
		S_DONE = 7'b1000000
	} state_t;

	state_t state_q, state_d;

	// configuration
	logic [2:0]        alg_q;
	logic [ID_W-1:0]   my_q;
	logic [8:0]        rcount_q;
	logic [8:0]        mcols_q;
	logic [3:0]        ord_q;

	// captured request
	logic [1:0]           vnet_q;
	logic [ID_W-1:0]      dest_q;
	logic [DEST_BITS-1:0] dset_q;
	logic [RND_W-1:0]     rnd_q;
	logic [7:0]           bq_q;
	logic [7:0]           rq_q;
	logic                 tbl_q;
	logic                 phase_q;

	// table state
	logic [7:0]        weight_q [MAX_LINKS];
	logic [DEPTH-1:0]  ent_vld_q;

	// scan
	logic [LINK_W:0]      scan_cnt_q;
	logic                 scan_v_s1;
	logic [LINK_W-1:0]    scan_link_s1;
	logic                 scan_ev_s1;
	logic [MAX_LINKS-1:0] match_q;
	logic [8:0]           best_q;
	logic [MAX_LINKS-1:0] eq_q;
	logic [LINK_W-1:0]    pick_q;
	logic [LINK_W-1:0]    seen_q;
	logic [LINK_W-1:0]    sel_q;
	logic [DIVR_W-1:0]    a_rem_q;
	logic [ID_W-1:0]      a_quo_q;

	// pending result
	logic [4:0]        res_dir_q;
	logic [2:0]        res_stage_q;
	logic [3:0]        res_link_q;
	logic              res_nr_q;

	logic                 in_fire;
	logic                 is_route;
	logic                 tbl_c;
	logic                 vnet_ok;
	logic                 ram_we;
	logic [ADDR_W-1:0]    waddr;
	logic [ADDR_W-1:0]    raddr;
	logic [DEST_BITS-1:0] rdata;
	logic                 scan_issue;
	logic                 hit;
	logic [MAX_LINKS-1:0] eq_c;
	logic [LINK_W:0]      cnt_c;
	logic                 ordered;
	logic [DIVR_W-1:0]    dir_div;
	logic                 out_load;
	div_req_t             div_req;
	div_rsp_t             div_rsp;
	logic [4:0]           dir_c;
	logic [2:0]           stage_c;

	assign cfg_ready = 1'b1;
	assign in_stall  = (state_q != S_IDLE);
	assign in_fire   = in_valid && !in_stall;
	assign is_route  = (kind == KIND_ROUTE);
	assign tbl_c     = (dest_id == my_q) || (alg_q == ALG_TABLE) || (alg_q == ALG_SPARE);
	assign vnet_ok   = int'(vnet) < NUM_VNETS;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alg_q    <= ALG_TABLE;
			my_q     <= '0;
			rcount_q <= 9'd1;
			mcols_q  <= 9'd1;
			ord_q    <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_ALGORITHM:     alg_q    <= cfg_data[2:0];
				CFG_MY_ROUTER:     my_q     <= cfg_data[ID_W-1:0];
				CFG_ROUTER_COUNT:  rcount_q <= cfg_data;
				CFG_MESH_COLUMNS:  mcols_q  <= cfg_data;
				CFG_ORDERED_VNETS: ord_q    <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	// table memory
	assign ram_we     = in_fire && (kind == KIND_SET) && vnet_ok;
	assign waddr      = ADDR_W'({vnet, table_link});
	assign raddr      = ADDR_W'({vnet_q, scan_cnt_q[LINK_W-1:0]});
	assign scan_issue = (state_q == S_SCAN) && !scan_cnt_q[LINK_W];

	rcu_ram #(
		.WIDTH(DEST_BITS),
		.DEPTH(DEPTH)
	) u_sets (
		.clk  (clk),
		.we   (ram_we),
		.waddr(waddr),
		.wdata(entry_set[DEST_BITS-1:0]),
		.raddr(raddr),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ent_vld_q <= '0;
			for (int i = 0; i < MAX_LINKS; i++) begin
				weight_q[i] <= '0;
			end
		end else if (in_fire) begin
			if (ram_we) begin
				ent_vld_q[waddr] <= 1'b1;
			end
			if (kind == KIND_WEIGHT) begin
				weight_q[table_link] <= link_cost;
			end
		end
	end

	assign hit = scan_v_s1 && scan_ev_s1 && (|(rdata & dset_q));

	always_comb begin
		cnt_c = '0;
		for (int i = 0; i < MAX_LINKS; i++) begin
			eq_c[i] = match_q[i] && ({1'b0, weight_q[i]} == best_q);
			cnt_c   = cnt_c + {{LINK_W{1'b0}}, eq_c[i]};
		end
	end

	assign ordered = ord_q[vnet_q];
	assign dir_div = (alg_q == ALG_XY) ? ((mcols_q == '0) ? 9'd1 : mcols_q)
	                                   : ((rcount_q == '0) ? 9'd1 : rcount_q);

	// divider requests: mesh/ring identifiers and candidate pick
	always_comb begin
		div_req = '0;
		if (state_q == S_IDLE) begin
			div_req.start    = in_fire && is_route && !tbl_c &&
			                   (alg_q == ALG_XY || alg_q == ALG_RING);
			div_req.dividend = RND_W'(my_q);
			div_req.divisor  = dir_div;
		end else if (state_q == S_PREP) begin
			div_req.start    = (cnt_c != '0) && !ordered;
			div_req.dividend = rnd_q;
			div_req.divisor  = DIVR_W'(cnt_c);
		end else if (state_q == S_DIV) begin
			div_req.start    = div_rsp.done && !tbl_q && !phase_q;
			div_req.dividend = RND_W'(dest_q);
			div_req.divisor  = dir_div;
		end
	end

	rcu_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (div_req),
		.rsp   (div_rsp)
	);

	// directional routing from registered operands
	always_comb begin
		logic [TORUS_W-1:0]   ca [3];
		logic [TORUS_W-1:0]   cb [3];
		logic [TORUS_W:0]     fwd;
		logic [TORUS_W:0]     back;
		logic signed [TORUS_W+2:0] dd [3];
		logic [4:0]           cx;
		logic [4:0]           cy;
		logic [ID_W-1:0]      diff;
		logic [2:0]           s;
		logic [DIVR_W:0]      cw;
		logic [DIVR_W:0]      ccw;

		dir_c   = DIR_LOCAL;
		stage_c = '0;
		for (int i = 0; i < 3; i++) begin
			ca[i] = my_q[i*TORUS_W +: TORUS_W];
			cb[i] = dest_q[i*TORUS_W +: TORUS_W];
			dd[i] = $signed({3'b000, cb[i]}) - $signed({3'b000, ca[i]});
			if (dd[i] > (TORUS_RADIX / 2)) begin
				dd[i] = dd[i] - (TORUS_W+3)'(TORUS_RADIX);
			end
			if (dd[i] < -(TORUS_RADIX / 2)) begin
				dd[i] = dd[i] + (TORUS_W+3)'(TORUS_RADIX);
			end
		end
		cx   = (dd[0] > 0) ? DIR_POSX : DIR_NEGX;
		cy   = (dd[1] > 0) ? DIR_POSY : DIR_NEGY;
		diff = my_q ^ dest_q;
		s    = '0;
		for (int i = 0; i < ID_W; i++) begin
			if (diff[i]) begin
				s = 3'(i);
			end
		end
		cw  = (div_rsp.rem >= a_rem_q) ? ({1'b0, div_rsp.rem} - {1'b0, a_rem_q})
		      : ({1'b0, div_rsp.rem} + {1'b0, dir_div} - {1'b0, a_rem_q});
		ccw = (a_rem_q >= div_rsp.rem) ? ({1'b0, a_rem_q} - {1'b0, div_rsp.rem})
		      : ({1'b0, a_rem_q} + {1'b0, dir_div} - {1'b0, div_rsp.rem});
		fwd  = '0;
		back = '0;

		unique case (alg_q)
			ALG_XY: begin
				if (div_rsp.rem != a_rem_q) begin
					dir_c = (div_rsp.rem >= a_rem_q) ? DIR_EAST : DIR_WEST;
				end else if (div_rsp.quot[ID_W-1:0] != a_quo_q) begin
					dir_c = (div_rsp.quot[ID_W-1:0] >= a_quo_q) ? DIR_NORTH : DIR_SOUTH;
				end
			end
			ALG_RING: begin
				dir_c = (cw <= ccw) ? DIR_CW : DIR_CCW;
			end
			ALG_TORUS: begin
				// first differing dimension wins
				for (int i = 2; i >= 0; i--) begin
					fwd  = (cb[i] >= ca[i]) ? ({1'b0, cb[i]} - {1'b0, ca[i]})
					       : ({1'b0, cb[i]} + (TORUS_W+1)'(TORUS_RADIX) - {1'b0, ca[i]});
					back = (TORUS_W+1)'(TORUS_RADIX) - fwd;
					if (fwd != '0) begin
						dir_c = DIR_POSX + 5'(2 * i) + ((fwd <= back) ? 5'd0 : 5'd1);
					end
				end
			end
			ALG_ADAPTIVE: begin
				if (dd[0] != 0 && dd[1] != 0) begin
					dir_c = rnd_q[0] ? cy : cx;
				end else if (dd[0] != 0) begin
					dir_c = cx;
				end else if (dd[1] != 0) begin
					dir_c = cy;
				end else if (dd[2] != 0) begin
					dir_c = (dd[2] > 0) ? DIR_POSZ : DIR_NEGZ;
				end
			end
			default: begin
				// butterfly and railway; identifiers differ on this path
				dir_c   = dest_q[s] ? DIR_UP : DIR_DOWN;
				stage_c = s;
				if (alg_q == ALG_RAILWAY && bq_q > rq_q) begin
					dir_c   = (my_q < dest_q) ? DIR_RIGHT : DIR_LEFT;
					stage_c = '0;
				end
			end
		endcase
	end

	assign out_load = (state_q == S_DONE) && (!out_valid || !out_stall);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_fire && is_route) begin
					if (tbl_c) begin
						state_d = vnet_ok ? S_SCAN : S_DONE;
					end else if (alg_q == ALG_XY || alg_q == ALG_RING) begin
						state_d = S_DIV;
					end else begin
						state_d = S_DIR;
					end
				end
			end
			S_SCAN: begin
				if (scan_v_s1 && scan_link_s1 == LINK_W'(MAX_LINKS - 1)) begin
					state_d = S_PREP;
				end
			end
			S_PREP: begin
				if (cnt_c == '0) begin
					state_d = S_DONE;
				end else if (ordered) begin
					state_d = S_SEL;
				end else begin
					state_d = S_DIV;
				end
			end
			S_DIV: begin
				if (div_rsp.done) begin
					if (tbl_q) begin
						state_d = S_SEL;
					end else if (phase_q) begin
						state_d = S_DIR;
					end
				end
			end
			S_SEL: begin
				if (eq_q[sel_q] && seen_q == pick_q) begin
					state_d = S_DONE;
				end
			end
			S_DIR:  state_d = S_DONE;
			S_DONE: begin
				if (out_load) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			scan_v_s1 <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			state_q   <= state_d;
			scan_v_s1 <= scan_issue;
			if (out_load) begin
				out_valid <= 1'b1;
			end else if (!out_stall) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		scan_link_s1 <= scan_cnt_q[LINK_W-1:0];
		scan_ev_s1   <= ent_vld_q[raddr];
		if (scan_issue) begin
			scan_cnt_q <= scan_cnt_q + 1'b1;
		end
		if (hit) begin
			match_q[scan_link_s1] <= 1'b1;
			if ({1'b0, weight_q[scan_link_s1]} < best_q) begin
				best_q <= {1'b0, weight_q[scan_link_s1]};
			end
		end

		unique case (state_q)
			S_IDLE: begin
				if (in_fire && is_route) begin
					vnet_q      <= vnet;
					dest_q      <= dest_id;
					dset_q      <= dest_set[DEST_BITS-1:0];
					rnd_q       <= random_value;
					bq_q        <= butterfly_queue;
					rq_q        <= railway_queue;
					tbl_q       <= tbl_c;
					phase_q     <= 1'b0;
					scan_cnt_q  <= '0;
					match_q     <= '0;
					best_q      <= 9'd256;
					res_dir_q   <= DIR_TABLE;
					res_stage_q <= '0;
					res_link_q  <= '0;
					res_nr_q    <= 1'b1;
				end
			end
			S_PREP: begin
				eq_q   <= eq_c;
				pick_q <= '0;
				seen_q <= '0;
				sel_q  <= '0;
			end
			S_DIV: begin
				if (div_rsp.done) begin
					if (tbl_q) begin
						pick_q <= div_rsp.rem[LINK_W-1:0];
					end else if (!phase_q) begin
						a_rem_q <= div_rsp.rem;
						a_quo_q <= div_rsp.quot[ID_W-1:0];
						phase_q <= 1'b1;
					end
				end
			end
			S_SEL: begin
				if (eq_q[sel_q]) begin
					if (seen_q == pick_q) begin
						res_link_q <= sel_q;
						res_nr_q   <= 1'b0;
					end
					seen_q <= seen_q + 1'b1;
				end
				sel_q <= sel_q + 1'b1;
			end
			S_DIR: begin
				res_dir_q   <= dir_c;
				res_stage_q <= stage_c;
				res_link_q  <= '0;
				res_nr_q    <= 1'b0;
			end
			default: ;
		endcase

		if (out_load) begin
			direction <= res_dir_q;
			stage     <= res_stage_q;
			out_link  <= res_link_q;
			no_route  <= res_nr_q;
		end
	end

endmodule

// File: rtl/rcu_checker.sv
// port-level checks of the route compute unit, bound to the top level
`timescale 1ns / 1ps
`include "assert_macros.svh"

module rcu_checker import rcu_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_stall,
	input logic [1:0] kind,
	input logic       out_valid,
	input logic       out_stall,
	input logic [4:0] direction,
	input logic [2:0] stage,
	input logic [3:0] out_link,
	input logic       no_route
);

	// a stalled result transaction holds
	`RCU_ASSERT_NXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(direction) && $stable(out_link) && $stable(no_route) && $stable(stage))

	// a route request leaves the unit stalled in the cycle after its acceptance
	`RCU_ASSERT_NXT(a_route_busy, clk, arst_n, in_valid && !in_stall && kind == KIND_ROUTE, in_stall)

	`RCU_ASSERT_IMP(a_no_route_fields, clk, arst_n, out_valid && no_route, direction == DIR_TABLE && out_link == 4'd0 && stage == 3'd0)

	`RCU_ASSERT_IMP(a_stage_dir, clk, arst_n, out_valid && stage != 3'd0, direction == DIR_UP || direction == DIR_DOWN)

endmodule

bind noc_route_compute_unit rcu_checker u_rcu_checker (.*);
